>>> src/dpcd_pkg.sv
// ----------------------------------------------------------------------------
// Defect pixel coordinate decoder package
// Shared types and constants for the record classifier, the record queue and
// the coordinate back end.
// ----------------------------------------------------------------------------
package dpcd_pkg;

  localparam int IDX_W   = 9;
  localparam int COORD_W = 16;
  localparam int BYTE_W  = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_GROUP1 = 2'd1,
    OP_HEADER = 2'd2,
    OP_GROUP2 = 2'd3
  } opcode_t;

  typedef enum logic [0:0] {
    CFG_ROW_FLIP_BASE  = 1'b0,
    CFG_CROP_ROW_START = 1'b1
  } cfg_index_t;

  localparam logic [BYTE_W-1:0]  HDR_FLAG           = 8'h55;
  localparam logic [COORD_W-1:0] ROW_FLIP_BASE_RST  = 16'd3015;
  localparam logic [COORD_W-1:0] CROP_ROW_START_RST = 16'h01AC;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               black;
  } defect_rec_t;

endpackage

>>> src/dpcd_front.sv
// ----------------------------------------------------------------------------
// Defect pixel coordinate decoder front end
// Accepts operations, tracks the defect count and the black group enable,
// unpacks record bytes and pushes kept records into the queue.
// ----------------------------------------------------------------------------
module dpcd_front #(
  parameter int MAX_DEFECTS = 287
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_opcode,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte0,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte1,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte2,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte3,
  input  logic                         q_full,
  output logic                         q_push,
  output dpcd_pkg::defect_rec_t        q_rec
);

  localparam int CNT_W = $clog2(MAX_DEFECTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEFECTS);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             black_en_r;
  logic             black_en_nxt;

  logic                         accept;
  logic                         is_rec;
  logic                         black;
  logic                         keep;
  logic [dpcd_pkg::COORD_W-1:0] x;
  logic [dpcd_pkg::COORD_W-1:0] y;
  dpcd_pkg::opcode_t            op;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign op       = dpcd_pkg::opcode_t'(in_opcode);

  always_comb begin
    is_rec       = 1'b0;
    black        = 1'b0;
    x            = '0;
    y            = '0;
    count_nxt    = count_r;
    black_en_nxt = black_en_r;
    unique case (op)
      dpcd_pkg::OP_START: begin
        count_nxt    = '0;
        black_en_nxt = 1'b0;
      end
      dpcd_pkg::OP_HEADER: begin
        black_en_nxt = (in_record_byte0 == dpcd_pkg::HDR_FLAG);
      end
      dpcd_pkg::OP_GROUP1: begin
        is_rec = 1'b1;
        y      = {in_record_byte0, in_record_byte1};
        x      = {in_record_byte2, in_record_byte3};
      end
      dpcd_pkg::OP_GROUP2: begin
        is_rec = black_en_r;
        black  = 1'b1;
        x      = {4'b0, in_record_byte0[7:4], in_record_byte1};
        y      = {4'b0, in_record_byte0[3:0], in_record_byte2};
      end
      default: begin
        is_rec = 1'b0;
      end
    endcase
    keep = is_rec && ((x | y) != '0) && (count_r < CNT_MAX);
    if (keep) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  assign q_push      = accept && keep;
  assign q_rec.index = dpcd_pkg::IDX_W'(count_r);
  assign q_rec.x     = x;
  assign q_rec.y     = y;
  assign q_rec.black = black;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      black_en_r <= 1'b0;
    end else if (accept) begin
      count_r    <= count_nxt;
      black_en_r <= black_en_nxt;
    end
  end

endmodule

>>> src/dpcd_queue.sv
// ----------------------------------------------------------------------------
// Defect pixel coordinate decoder record queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module dpcd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dpcd_pkg::defect_rec_t rec_in,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output dpcd_pkg::defect_rec_t rec_out
);

  dpcd_pkg::defect_rec_t             slot_r [dpcd_pkg::QUEUE_DEPTH];
  logic [dpcd_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [dpcd_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [dpcd_pkg::QCNT_W-1:0]       cnt_r;
  logic [dpcd_pkg::QCNT_W-1:0]       cnt_nxt;

  assign full    = (cnt_r == dpcd_pkg::QCNT_W'(dpcd_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rec_out = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + dpcd_pkg::QCNT_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - dpcd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + dpcd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + dpcd_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= rec_in;
    end
  end

endmodule

>>> src/dpcd_back.sv
// ----------------------------------------------------------------------------
// Defect pixel coordinate decoder back end
// Pops queued records, computes snapshot, binned and video60 coordinates and
// holds them in the output register until the receiver takes them.
// ----------------------------------------------------------------------------
module dpcd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dpcd_pkg::COORD_W-1:0] row_flip_base,
  input  logic [dpcd_pkg::COORD_W-1:0] crop_row_start,
  input  logic                         q_empty,
  input  dpcd_pkg::defect_rec_t        q_rec,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dpcd_pkg::IDX_W-1:0]   out_defect_index,
  output logic [dpcd_pkg::COORD_W-1:0] out_snapshot_x,
  output logic [dpcd_pkg::COORD_W-1:0] out_snapshot_y,
  output logic [dpcd_pkg::COORD_W-1:0] out_binned_x,
  output logic [dpcd_pkg::COORD_W-1:0] out_binned_y,
  output logic [dpcd_pkg::COORD_W-1:0] out_video60_y,
  output logic                         out_from_black_group
);

  logic                         valid_r;
  logic                         valid_nxt;
  logic [dpcd_pkg::IDX_W-1:0]   index_r;
  logic [dpcd_pkg::COORD_W-1:0] snap_x_r;
  logic [dpcd_pkg::COORD_W-1:0] snap_y_r;
  logic [dpcd_pkg::COORD_W-1:0] bin_x_r;
  logic [dpcd_pkg::COORD_W-1:0] bin_y_r;
  logic [dpcd_pkg::COORD_W-1:0] v60_y_r;
  logic                         black_r;

  logic [17:0]                  fy;
  logic [17:0]                  row;
  logic [17:0]                  row_adj;
  logic [18:0]                  d;
  logic [18:0]                  d_adj;
  logic [dpcd_pkg::COORD_W-1:0] rem16;
  logic [dpcd_pkg::COORD_W-1:0] bin_x;
  logic [dpcd_pkg::COORD_W-1:0] bin_y;
  logic [dpcd_pkg::COORD_W-1:0] v60_y;

  // Signed values are kept in two's complement; the top bit is the sign.
  always_comb begin
    fy      = {2'b0, row_flip_base} - {2'b0, q_rec.y};
    row     = q_rec.black ? {2'b0, q_rec.y} : fy;
    row_adj = row + {16'b0, {2{row[17]}}};
    d       = {row[17], row} - {3'b0, crop_row_start};
    d_adj   = d + {16'b0, {3{d[18]}}};
    if (!d[0]) begin
      rem16 = '0;
    end else if (d[18]) begin
      rem16 = '1;
    end else begin
      rem16 = dpcd_pkg::COORD_W'(1);
    end
    bin_x = {1'b0, q_rec.x[15:2], q_rec.x[0]};
    bin_y = {row_adj[16:2], q_rec.y[0]};
    v60_y = {d_adj[17:3], 1'b0} + rem16;
  end

  assign q_pop     = !q_empty && (!valid_r || !out_stall);
  assign valid_nxt = q_pop || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      index_r  <= q_rec.index;
      snap_x_r <= q_rec.x;
      snap_y_r <= row[15:0];
      bin_x_r  <= bin_x;
      bin_y_r  <= bin_y;
      v60_y_r  <= v60_y;
      black_r  <= q_rec.black;
    end
  end

  assign out_valid            = valid_r;
  assign out_defect_index     = index_r;
  assign out_snapshot_x       = snap_x_r;
  assign out_snapshot_y       = snap_y_r;
  assign out_binned_x         = bin_x_r;
  assign out_binned_y         = bin_y_r;
  assign out_video60_y        = v60_y_r;
  assign out_from_black_group = black_r;

endmodule

>>> src/defect_pixel_coord_decoder_top.sv
// ----------------------------------------------------------------------------
// Defect pixel coordinate decoder
// Turns defect pixel calibration records into per-mode pixel coordinates.
// ----------------------------------------------------------------------------
// The input channel takes one operation per transfer: start, first group
// record, black defect header or second group record. Start and header
// operations only update the internal count and enable. A record that is
// kept yields one transfer on the output channel with its list index and
// its snapshot, binned and video60 coordinates.
// The front end classifies an operation in the cycle of its transfer and
// writes kept records into a two-entry queue; the back end computes the
// coordinates into the output register. out_valid rises once a kept record
// has passed through the queue and the output register, and one operation
// per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the output register holds its result, the queue
// fills, and in_stall rises once both queue entries are occupied.
// Reset clears the count, the black group enable, the queue and the output
// valid, and loads the configuration registers with their default values.
// Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module defect_pixel_coord_decoder_top #(
  parameter int MAX_DEFECTS = 287
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_opcode,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte0,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte1,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte2,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte3,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dpcd_pkg::IDX_W-1:0]   out_defect_index,
  output logic [dpcd_pkg::COORD_W-1:0] out_snapshot_x,
  output logic [dpcd_pkg::COORD_W-1:0] out_snapshot_y,
  output logic [dpcd_pkg::COORD_W-1:0] out_binned_x,
  output logic [dpcd_pkg::COORD_W-1:0] out_binned_y,
  output logic [dpcd_pkg::COORD_W-1:0] out_video60_y,
  output logic                         out_from_black_group,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [0:0]                   cfg_index,
  input  logic [dpcd_pkg::COORD_W-1:0] cfg_data
);

  logic [dpcd_pkg::COORD_W-1:0] row_flip_base_r;
  logic [dpcd_pkg::COORD_W-1:0] crop_row_start_r;

  logic                  q_full;
  logic                  q_push;
  logic                  q_empty;
  logic                  q_pop;
  dpcd_pkg::defect_rec_t q_wr_rec;
  dpcd_pkg::defect_rec_t q_rd_rec;
  dpcd_pkg::cfg_index_t  cfg_sel;

  assign cfg_ready = 1'b1;
  assign cfg_sel   = dpcd_pkg::cfg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_flip_base_r  <= dpcd_pkg::ROW_FLIP_BASE_RST;
      crop_row_start_r <= dpcd_pkg::CROP_ROW_START_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_sel)
        dpcd_pkg::CFG_ROW_FLIP_BASE:  row_flip_base_r  <= cfg_data;
        dpcd_pkg::CFG_CROP_ROW_START: crop_row_start_r <= cfg_data;
        default: begin
          row_flip_base_r <= row_flip_base_r;
        end
      endcase
    end
  end

  dpcd_front #(
    .MAX_DEFECTS (MAX_DEFECTS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_record_byte0 (in_record_byte0),
    .in_record_byte1 (in_record_byte1),
    .in_record_byte2 (in_record_byte2),
    .in_record_byte3 (in_record_byte3),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_rec           (q_wr_rec)
  );

  dpcd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .rec_in  (q_wr_rec),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rec_out (q_rd_rec)
  );

  dpcd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .row_flip_base        (row_flip_base_r),
    .crop_row_start       (crop_row_start_r),
    .q_empty              (q_empty),
    .q_rec                (q_rd_rec),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_defect_index     (out_defect_index),
    .out_snapshot_x       (out_snapshot_x),
    .out_snapshot_y       (out_snapshot_y),
    .out_binned_x         (out_binned_x),
    .out_binned_y         (out_binned_y),
    .out_video60_y        (out_video60_y),
    .out_from_black_group (out_from_black_group)
  );

endmodule

>>> tb/defect_coord_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Defect coordinate checker
// Watches the record, result and register channels of the decoder. It keeps
// its own copy of the count, the black group enable and both registers. For
// each accepted record it predicts the coordinates, and it compares every
// result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module defect_coord_checker #(
  parameter int MAX_DEFECTS = 287
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   in_opcode,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte0,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte1,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte2,
  input  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte3,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [dpcd_pkg::IDX_W-1:0]   out_defect_index,
  input  logic [dpcd_pkg::COORD_W-1:0] out_snapshot_x,
  input  logic [dpcd_pkg::COORD_W-1:0] out_snapshot_y,
  input  logic [dpcd_pkg::COORD_W-1:0] out_binned_x,
  input  logic [dpcd_pkg::COORD_W-1:0] out_binned_y,
  input  logic [dpcd_pkg::COORD_W-1:0] out_video60_y,
  input  logic                         out_from_black_group,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [0:0]                   cfg_index,
  input  logic [dpcd_pkg::COORD_W-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [dpcd_pkg::IDX_W-1:0]   index;
    logic [dpcd_pkg::COORD_W-1:0] snap_x;
    logic [dpcd_pkg::COORD_W-1:0] snap_y;
    logic [dpcd_pkg::COORD_W-1:0] bin_x;
    logic [dpcd_pkg::COORD_W-1:0] bin_y;
    logic [dpcd_pkg::COORD_W-1:0] v60_y;
    logic                         black;
  } defect_coords_t;

  defect_coords_t               expected_coords[$];
  logic [dpcd_pkg::COORD_W-1:0] flip_base;
  logic [dpcd_pkg::COORD_W-1:0] crop_start;
  int                           kept_count;
  logic                         black_enabled;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name,
                               input logic [dpcd_pkg::COORD_W-1:0] got,
                               input logic [dpcd_pkg::COORD_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic int half_bin(input int q, input int r);
    return (q / 4) * 2 + (r % 2);
  endfunction

  function automatic int window_row(input int row);
    int d;
    d = row - int'(crop_start);
    return (d / 8) * 2 + (d % 2);
  endfunction

  function automatic bit predict_coords(input dpcd_pkg::opcode_t op, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [7:0] b3,
                                        output defect_coords_t res);
    int x;
    int y;
    int row;
    bit black;
    res = '0;
    x = 0;
    y = 0;
    row = 0;
    black = 1'b0;
    case (op)
      dpcd_pkg::OP_START: begin
        kept_count = 0;
        black_enabled = 1'b0;
        return 1'b0;
      end
      dpcd_pkg::OP_HEADER: begin
        black_enabled = (b0 == dpcd_pkg::HDR_FLAG);
        return 1'b0;
      end
      dpcd_pkg::OP_GROUP1: begin
        y = int'({b0, b1});
        x = int'({b2, b3});
        row = int'(flip_base) - y;
      end
      default: begin
        if (!black_enabled) return 1'b0;
        x = int'({b0[7:4], b1});
        y = int'({b0[3:0], b2});
        row = y;
        black = 1'b1;
      end
    endcase
    if (x == 0 && y == 0) return 1'b0;
    if (kept_count >= MAX_DEFECTS) return 1'b0;
    res.index  = kept_count[dpcd_pkg::IDX_W-1:0];
    res.snap_x = x[dpcd_pkg::COORD_W-1:0];
    res.snap_y = row[dpcd_pkg::COORD_W-1:0];
    res.bin_x  = 16'(half_bin(x, x));
    res.bin_y  = 16'(half_bin(row, y));
    res.v60_y  = 16'(window_row(row));
    res.black  = black;
    kept_count++;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    defect_coords_t want;
    if (!rst_n) begin
      flip_base = dpcd_pkg::ROW_FLIP_BASE_RST;
      crop_start = dpcd_pkg::CROP_ROW_START_RST;
      kept_count = 0;
      black_enabled = 1'b0;
      fail_count = 0;
      expected_coords.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_coords.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer, index %0d",
                                    out_defect_index));
        end else begin
          want = expected_coords.pop_front();
          compare_field("defect_index", 16'(out_defect_index), 16'(want.index));
          compare_field("snapshot_x", out_snapshot_x, want.snap_x);
          compare_field("snapshot_y", out_snapshot_y, want.snap_y);
          compare_field("binned_x", out_binned_x, want.bin_x);
          compare_field("binned_y", out_binned_y, want.bin_y);
          compare_field("video60_y", out_video60_y, want.v60_y);
          compare_field("from_black_group", 16'(out_from_black_group),
                        16'(want.black));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dpcd_pkg::CFG_ROW_FLIP_BASE) begin
          flip_base = cfg_data;
        end else begin
          crop_start = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        if (predict_coords(dpcd_pkg::opcode_t'(in_opcode), in_record_byte0,
                           in_record_byte1, in_record_byte2, in_record_byte3,
                           want)) begin
          expected_coords.push_back(want);
        end
      end
    end
    pending = expected_coords.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Defect pixel coordinate decoder testbench
// Drives directed and random record streams under several register settings,
// with random idle bursts on the record side and stall bursts on the result
// side, and leaves the checking to the coordinate checker.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT = 100000;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  dpcd_pkg::opcode_t            in_opcode;
  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte0;
  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte1;
  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte2;
  logic [dpcd_pkg::BYTE_W-1:0]  in_record_byte3;
  logic                         out_valid;
  logic                         out_stall;
  logic [dpcd_pkg::IDX_W-1:0]   out_defect_index;
  logic [dpcd_pkg::COORD_W-1:0] out_snapshot_x;
  logic [dpcd_pkg::COORD_W-1:0] out_snapshot_y;
  logic [dpcd_pkg::COORD_W-1:0] out_binned_x;
  logic [dpcd_pkg::COORD_W-1:0] out_binned_y;
  logic [dpcd_pkg::COORD_W-1:0] out_video60_y;
  logic                         out_from_black_group;
  logic                         cfg_valid;
  logic                         cfg_ready;
  dpcd_pkg::cfg_index_t         cfg_index;
  logic [dpcd_pkg::COORD_W-1:0] cfg_data;
  int                           fail_count;
  int                           pending;
  int                           cycle_count = 0;
  bit                           idle_en;

  defect_pixel_coord_decoder_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_record_byte0      (in_record_byte0),
    .in_record_byte1      (in_record_byte1),
    .in_record_byte2      (in_record_byte2),
    .in_record_byte3      (in_record_byte3),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_defect_index     (out_defect_index),
    .out_snapshot_x       (out_snapshot_x),
    .out_snapshot_y       (out_snapshot_y),
    .out_binned_x         (out_binned_x),
    .out_binned_y         (out_binned_y),
    .out_video60_y        (out_video60_y),
    .out_from_black_group (out_from_black_group),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  defect_coord_checker coord_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_record_byte0      (in_record_byte0),
    .in_record_byte1      (in_record_byte1),
    .in_record_byte2      (in_record_byte2),
    .in_record_byte3      (in_record_byte3),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_defect_index     (out_defect_index),
    .out_snapshot_x       (out_snapshot_x),
    .out_snapshot_y       (out_snapshot_y),
    .out_binned_x         (out_binned_x),
    .out_binned_y         (out_binned_y),
    .out_video60_y        (out_video60_y),
    .out_from_black_group (out_from_black_group),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAIL defect_pixel_coord_decoder_top");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_op(input dpcd_pkg::opcode_t op, input logic [7:0] b0,
                         input logic [7:0] b1, input logic [7:0] b2,
                         input logic [7:0] b3);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_record_byte0 <= b0;
    in_record_byte1 <= b1;
    in_record_byte2 <= b2;
    in_record_byte3 <= b3;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input dpcd_pkg::cfg_index_t idx,
                           input logic [dpcd_pkg::COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [dpcd_pkg::COORD_W-1:0] base,
                            input logic [dpcd_pkg::COORD_W-1:0] crop);
    write_reg(dpcd_pkg::CFG_ROW_FLIP_BASE, base);
    write_reg(dpcd_pkg::CFG_CROP_ROW_START, crop);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic rand_item(input bit allow_start);
    int pick;
    dpcd_pkg::opcode_t op;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    pick = $urandom_range(0, 99);
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    b2 = 8'($urandom);
    b3 = 8'($urandom);
    if (allow_start && pick < 3) begin
      op = dpcd_pkg::OP_START;
    end else if (pick < (allow_start ? 10 : 3)) begin
      op = dpcd_pkg::OP_HEADER;
      if ($urandom_range(0, 1)) b0 = dpcd_pkg::HDR_FLAG;
    end else if (pick < 50) begin
      op = dpcd_pkg::OP_GROUP1;
      if ($urandom_range(0, 19) == 0) {b0, b1, b2, b3} = '0;
    end else begin
      op = dpcd_pkg::OP_GROUP2;
      if ($urandom_range(0, 19) == 0) {b0, b1, b2} = '0;
    end
    send_op(op, b0, b1, b2, b3);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = dpcd_pkg::OP_START;
    in_record_byte0 = '0;
    in_record_byte1 = '0;
    in_record_byte2 = '0;
    in_record_byte3 = '0;
    cfg_valid       = 1'b0;
    cfg_index       = dpcd_pkg::CFG_ROW_FLIP_BASE;
    cfg_data        = '0;
    idle_en         = 1'b1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_op(dpcd_pkg::OP_START,  8'h00, 8'h00, 8'h00, 8'h00);
    send_op(dpcd_pkg::OP_GROUP1, 8'h00, 8'h00, 8'h00, 8'h00);
    send_op(dpcd_pkg::OP_GROUP1, 8'h00, 8'h00, 8'h00, 8'h01);
    send_op(dpcd_pkg::OP_GROUP1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_op(dpcd_pkg::OP_GROUP1, 8'h0B, 8'hC7, 8'h00, 8'h02);
    send_op(dpcd_pkg::OP_GROUP1, 8'h0B, 8'hC8, 8'h00, 8'h00);
    send_op(dpcd_pkg::OP_GROUP2, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_op(dpcd_pkg::OP_HEADER, 8'h54, 8'h00, 8'h00, 8'h00);
    send_op(dpcd_pkg::OP_GROUP2, 8'h12, 8'h34, 8'h56, 8'h00);
    send_op(dpcd_pkg::OP_HEADER, dpcd_pkg::HDR_FLAG, 8'hFF, 8'hFF, 8'hFF);
    send_op(dpcd_pkg::OP_GROUP2, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_op(dpcd_pkg::OP_GROUP2, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_op(dpcd_pkg::OP_GROUP2, 8'h10, 8'h00, 8'h05, 8'h00);
    send_op(dpcd_pkg::OP_GROUP2, 8'h01, 8'h00, 8'hAC, 8'hAA);
    send_op(dpcd_pkg::OP_GROUP1, 8'h00, 8'h07, 8'h12, 8'h34);
    send_op(dpcd_pkg::OP_HEADER, 8'hAA, 8'h00, 8'h00, 8'h00);
    send_op(dpcd_pkg::OP_GROUP2, 8'h55, 8'hAA, 8'h55, 8'h00);
    send_op(dpcd_pkg::OP_HEADER, dpcd_pkg::HDR_FLAG, 8'h00, 8'h00, 8'h00);
    send_op(dpcd_pkg::OP_GROUP2, 8'hA5, 8'h5A, 8'hC3, 8'h3C);
    send_op(dpcd_pkg::OP_START,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_op(dpcd_pkg::OP_GROUP2, 8'h11, 8'h11, 8'h11, 8'h11);
    send_op(dpcd_pkg::OP_GROUP1, 8'h80, 8'h00, 8'h00, 8'h80);

    drain();
    set_config(16'h0000, 16'h0000);
    repeat (100) rand_item(1'b1);

    drain();
    set_config(16'hFFFF, 16'hFFFF);
    send_op(dpcd_pkg::OP_START, 8'h00, 8'h00, 8'h00, 8'h00);
    send_op(dpcd_pkg::OP_HEADER, dpcd_pkg::HDR_FLAG, 8'h00, 8'h00, 8'h00);
    repeat (400) rand_item(1'b0);

    drain();
    set_config(16'($urandom), 16'($urandom));
    repeat (120) rand_item(1'b1);

    drain();
    idle_en = 1'b0;
    set_config(dpcd_pkg::ROW_FLIP_BASE_RST, dpcd_pkg::CROP_ROW_START_RST);
    repeat (100) rand_item(1'b1);

    drain();
    if (fail_count == 0) begin
      $display("PASS defect_pixel_coord_decoder_top");
    end else begin
      $display("FAIL defect_pixel_coord_decoder_top");
    end
    $finish;
  end

endmodule
